FILE: rtl/esrs_pkg.sv
package esrs_pkg;

    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 11;
    localparam int LOOP_W      = 16;
    localparam int FRAC_W      = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED   = 3'd0,
        CFG_DELAY     = 3'd1,
        CFG_DURATION  = 3'd2,
        CFG_LOOPS     = 3'd3,
        CFG_RATE      = 3'd4,
        CFG_BURST     = 3'd5,
        CFG_CAPACITY  = 3'd6
    } t_cfg_idx;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load_in;
        logic step_time;
        logic step_span;
        logic step_mul;
        logic finish;
    } t_cmd;

endpackage

FILE: rtl/esrs_ctrl.sv
module esrs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_ready,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output esrs_pkg::t_cmd o_cmd
);
    import esrs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TIME = 5'b00010,
        S_SPAN = 5'b00100,
        S_MUL  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   accept;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_FIN) && out_free);
    assign accept     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.load_in = accept;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_TIME;
                end
            end
            S_TIME: begin
                o_cmd.step_time = 1'b1;
                n_state = S_SPAN;
            end
            S_SPAN: begin
                o_cmd.step_span = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.step_mul = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = accept ? S_TIME : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/esrs_dp.sv
module esrs_dp #(
    parameter int MAX_PARTICLES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  esrs_pkg::t_cmd                      i_cmd,
    input  logic                                i_cfg_we,
    input  logic [esrs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [esrs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [esrs_pkg::IN_TDATA_W-1:0]     i_in_data,
    output logic [esrs_pkg::OUT_TDATA_W-1:0]    o_out_data
);
    import esrs_pkg::*;

    localparam int CW    = $clog2(MAX_PARTICLES + 1);
    localparam int CNT_W = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int STOP_W = TIME_W + LOOP_W + 1;
    localparam int PROD_W = 2 * TIME_W;
    localparam int ACC_W  = PROD_W - FRAC_W + 1;
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_PARTICLES);
    localparam logic [ACC_W-1:0] MAX_Q = ACC_W'(MAX_PARTICLES) << FRAC_W;

    // Configuration registers.
    logic                    r_enabled;
    logic [TIME_W-1:0]       r_delay;
    logic [TIME_W-1:0]       r_duration;
    logic [LOOP_W-1:0]       r_loops;
    logic [TIME_W-1:0]       r_rate;
    logic [COUNT_W-1:0]      r_burst;
    logic [COUNT_W-1:0]      r_capacity;

    // Emitter state.
    logic [TIME_W-1:0]       r_elapsed;
    logic [FRAC_W-1:0]       r_frac;
    logic                    r_burst_done;

    // Per-item working registers.
    logic [TIME_W-1:0]       r_tick;
    logic [COUNT_W-1:0]      r_live;
    logic                    r_null;
    logic [STOP_W-2:0]       r_stop_prod;
    logic [TIME_W-1:0]       r_now;
    logic [STOP_W-1:0]       r_stop;
    logic [CNT_W-1:0]        r_cap;
    logic [CNT_W-1:0]        r_avail;
    logic [TIME_W-1:0]       r_span;
    logic                    r_fire;
    logic [PROD_W-1:0]       r_prod;
    logic [CNT_W-1:0]        r_burst_part;
    logic [OUT_TDATA_W-1:0]  r_result;

    logic [TIME_W:0]         time_sum;
    logic [CNT_W-1:0]        cap_ext;
    logic [CNT_W-1:0]        cap_eff;
    logic [CNT_W-1:0]        live_ext;
    logic [TIME_W-1:0]       span_lo;
    logic [TIME_W-1:0]       span_hi;
    logic [TIME_W-1:0]       span;
    logic [CNT_W-1:0]        burst_ext;
    logic [ACC_W-1:0]        acc_sum;
    logic [ACC_W-1:0]        acc_cap;
    logic [CNT_W-1:0]        whole;
    logic [CNT_W:0]          total_raw;
    logic [CNT_W-1:0]        total;
    logic [CNT_W-1:0]        accepted;
    logic [CNT_W-1:0]        dropped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= 1'b0;
            r_delay    <= '0;
            r_duration <= '0;
            r_loops    <= LOOP_W'(1);
            r_rate     <= '0;
            r_burst    <= '0;
            r_capacity <= COUNT_W'(1024);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ENABLED:  r_enabled  <= i_cfg_data[0];
                CFG_DELAY:    r_delay    <= i_cfg_data[TIME_W-1:0];
                CFG_DURATION: r_duration <= i_cfg_data[TIME_W-1:0];
                CFG_LOOPS:    r_loops    <= i_cfg_data[LOOP_W-1:0];
                CFG_RATE:     r_rate     <= i_cfg_data[TIME_W-1:0];
                CFG_BURST:    r_burst    <= i_cfg_data[COUNT_W-1:0];
                CFG_CAPACITY: r_capacity <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign time_sum  = {1'b0, r_elapsed} + {1'b0, r_tick};
    assign cap_ext   = CNT_W'(r_capacity);
    assign cap_eff   = (cap_ext > MAX_C) ? MAX_C : cap_ext;
    assign live_ext  = CNT_W'(r_live);

    assign span_lo = (r_elapsed > r_delay) ? r_elapsed : r_delay;
    assign span_hi = ((r_loops != '0) && (r_stop < STOP_W'(r_now)))
                     ? r_stop[TIME_W-1:0] : r_now;
    assign span    = ((r_now <= r_delay) || (r_duration == '0) || (span_hi <= span_lo))
                     ? '0 : span_hi - span_lo;

    assign burst_ext = CNT_W'(r_burst);

    assign acc_sum   = ACC_W'(r_prod[PROD_W-1:FRAC_W]) + ACC_W'(r_frac);
    assign acc_cap   = (acc_sum > MAX_Q) ? MAX_Q : acc_sum;
    assign whole     = acc_cap[FRAC_W +: CNT_W];
    assign total_raw = {1'b0, r_burst_part} + {1'b0, whole};
    assign total     = (total_raw > {1'b0, MAX_C}) ? MAX_C : total_raw[CNT_W-1:0];
    assign accepted  = (total < r_avail) ? total : r_avail;
    assign dropped   = total - accepted;

    // Reads configuration only; the user keeps it stable while items run (unchecked).
    always_ff @(posedge i_clk) begin
        r_stop_prod <= r_duration * r_loops;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_tick <= i_in_data[TIME_W-1:0];
            r_live <= i_in_data[TIME_W +: COUNT_W];
            r_null <= !r_enabled || (i_in_data[TIME_W-1:0] == '0);
        end
        if (i_cmd.step_time) begin
            r_now   <= time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
            r_stop  <= STOP_W'(r_delay) + STOP_W'(r_stop_prod);
            r_cap   <= cap_eff;
            r_avail <= (cap_eff > live_ext) ? cap_eff - live_ext : '0;
        end
        if (i_cmd.step_span) begin
            r_span <= span;
            r_fire <= !r_burst_done && (r_elapsed <= r_delay) && (r_now >= r_delay);
        end
        if (i_cmd.step_mul) begin
            r_prod       <= PROD_W'(r_rate) * PROD_W'(r_span);
            r_burst_part <= !r_fire ? '0 : ((burst_ext < r_cap) ? burst_ext : r_cap);
        end
        if (i_cmd.finish) begin
            if (r_null) begin
                r_result <= '0;
            end else begin
                r_result <= OUT_TDATA_W'({r_fire, dropped[COUNT_W-1:0],
                                          accepted[COUNT_W-1:0]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed    <= '0;
            r_frac       <= '0;
            r_burst_done <= 1'b0;
        end else if (i_cmd.finish && !r_null) begin
            r_elapsed    <= r_now;
            r_frac       <= acc_cap[FRAC_W-1:0];
            r_burst_done <= r_burst_done || r_fire;
        end
    end

    assign o_out_data = r_result;

endmodule

FILE: rtl/emitter_spawn_rate_scheduler.sv
// After an item is accepted, the four-step sequencer (time update, span, rate multiply,
// accumulate and limit) brings its result into the output register, one item at a time; the
// last step waits while the output register holds a result that has not been taken.
// A new item is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) restores register defaults and clears elapsed time,
// the spawn accumulator and the burst flag.
module emitter_spawn_rate_scheduler #(
    parameter int MAX_PARTICLES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [esrs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [esrs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tick_length [31:0], live_count [42:32], zero fill above.
    input  logic [esrs_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // accepted_spawns [10:0], dropped_spawns [21:11], burst_fired [22], zero fill above.
    output logic [esrs_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);
    import esrs_pkg::*;

    t_cmd cmd;

    esrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_out_ready (i_m_tready),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .o_cmd       (cmd)
    );

    esrs_dp #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_s_tdata),
        .o_out_data (o_m_tdata)
    );

endmodule
